FILE: sv/aps_pkg.sv
// ----------------------------------------------------------------------------
// aps_pkg
// Shared types and constants for the aging priority scheduler: slot record,
// cell control group, operation codes and state machine encodings.
// ----------------------------------------------------------------------------
package aps_pkg;

    // table geometry
    localparam int TASK_SLOTS = 16;
    localparam int IDX_W      = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

    // priority limits
    localparam logic signed [7:0] PRIO_HIGHEST = -8'sd20;
    localparam logic signed [7:0] PRIO_LOWEST  = 8'sd20;
    localparam logic signed [8:0] AGED_FLOOR   = -9'sd128;

    // operation codes
    typedef enum logic [2:0] {
        OP_CREATE   = 3'd0,
        OP_READY    = 3'd1,
        OP_REMOVE   = 3'd2,
        OP_SET_PRIO = 3'd3,
        OP_READ     = 3'd4,
        OP_SCHEDULE = 3'd5
    } op_t;

    // one task slot as it travels around the ring
    typedef struct packed {
        logic              ready;
        logic signed [5:0] base;
        logic signed [7:0] aged;
    } slot_t;

    // control shared by every cell
    typedef struct packed {
        logic              shift;
        logic              wr_create;
        logic              wr_ready;
        logic              wr_remove;
        logic              wr_prio;
        logic signed [5:0] prio;
    } cell_ctl_t;

    // schedule outcome handed to the top level
    typedef struct packed {
        logic             done;
        logic             none;
        logic [IDX_W-1:0] best;
    } sched_res_t;

    // scan sequencer states
    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_SCAN,
        SQ_AGE
    } seq_state_t;

    // top level transaction states
    typedef enum logic [1:0] {
        TP_IDLE,
        TP_BUSY,
        TP_HOLD
    } top_state_t;

endpackage

FILE: sv/aps_cell.sv
// ----------------------------------------------------------------------------
// aps_cell
// One task slot of the ring. Holds ready mark, base and aged priority; takes
// its neighbor's slot on a shift, otherwise applies addressed writes.
// ----------------------------------------------------------------------------
module aps_cell
    import aps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_ctl_t ctl,
    input  logic      sel,
    input  slot_t     shift_in,
    output slot_t     slot
);

    slot_t slot_reg;
    slot_t slot_next;

    // shift or addressed update
    always_comb
    begin
        slot_next = slot_reg;
        if (ctl.shift)
        begin
            slot_next = shift_in;
        end
        else if (sel)
        begin
            if (ctl.wr_create)
            begin
                slot_next.ready = 1'b1;
                slot_next.base  = 6'sd0;
                slot_next.aged  = 8'sd0;
            end
            if (ctl.wr_ready)
            begin
                slot_next.ready = 1'b1;
            end
            if (ctl.wr_remove)
            begin
                slot_next.ready = 1'b0;
            end
            if (ctl.wr_prio)
            begin
                slot_next.base = ctl.prio;
                slot_next.aged = {{2{ctl.prio[5]}}, ctl.prio};
            end
        end
    end

    // slot storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

    assign slot = slot_reg;

endmodule

FILE: sv/aps_seq.sv
// ----------------------------------------------------------------------------
// aps_seq
// Schedule sequencer at the head of the ring. A scan rotation finds the ready
// slot with the lowest aged priority; for a user task an aging rotation then
// resets the winner to base and ages each other ready slot passing the head.
// ----------------------------------------------------------------------------
module aps_seq
    import aps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [3:0] aging_step,
    input  slot_t      head,
    output slot_t      feedback,
    output logic       shift,
    output sched_res_t res
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_SLOTS - 1);
    localparam logic [IDX_W-1:0] SYS_MAX  = IDX_W'(1);

    seq_state_t        state_reg, state_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic [IDX_W-1:0]  best_reg, best_next;
    logic signed [7:0] best_aged_reg, best_aged_next;
    logic              found_reg, found_next;
    logic              none_reg, none_next;
    logic              done_reg, done_next;
    logic signed [8:0] diff;
    logic              better;

    // aged priority less the step, with floor
    assign diff   = {head.aged[7], head.aged} - $signed({5'b0, aging_step});
    assign better = head.ready && (!found_reg || (head.aged < best_aged_reg));

    // sequencer next state and head rewrite
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        best_next      = best_reg;
        best_aged_next = best_aged_reg;
        found_next     = found_reg;
        none_next      = none_reg;
        done_next      = 1'b0;
        shift          = 1'b0;
        feedback       = head;
        unique case (state_reg)
            SQ_IDLE:
            begin
                if (start)
                begin
                    state_next = SQ_SCAN;
                    cnt_next   = '0;
                    found_next = 1'b0;
                    best_next  = '0;
                end
            end
            SQ_SCAN:
            begin
                shift    = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (better)
                begin
                    best_next      = cnt_reg;
                    best_aged_next = head.aged;
                    found_next     = 1'b1;
                end
                if (cnt_reg == LAST_IDX)
                begin
                    cnt_next = '0;
                    if (!found_next)
                    begin
                        state_next = SQ_IDLE;
                        none_next  = 1'b1;
                        done_next  = 1'b1;
                    end
                    else if (best_next <= SYS_MAX)
                    begin
                        state_next = SQ_IDLE;
                        none_next  = 1'b0;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        state_next = SQ_AGE;
                    end
                end
            end
            SQ_AGE:
            begin
                shift    = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == best_reg)
                begin
                    feedback.aged = {{2{head.base[5]}}, head.base};
                end
                else if (head.ready)
                begin
                    feedback.aged = (diff < AGED_FLOOR) ? 8'sh80 : diff[7:0];
                end
                if (cnt_reg == LAST_IDX)
                begin
                    cnt_next   = '0;
                    state_next = SQ_IDLE;
                    none_next  = 1'b0;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                state_next = SQ_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SQ_IDLE;
            cnt_reg   <= '0;
            found_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            found_reg <= found_next;
            done_reg  <= done_next;
        end
    end

    // best candidate and outcome
    always_ff @(posedge clk)
    begin
        best_reg      <= best_next;
        best_aged_reg <= best_aged_next;
        none_reg      <= none_next;
    end

    assign res.done = done_reg;
    assign res.none = none_reg;
    assign res.best = best_reg;

endmodule

FILE: sv/aging_priority_scheduler.sv
// ----------------------------------------------------------------------------
// aging_priority_scheduler
// Task table with ready marks, base and aged priorities, and a schedule
// operation that picks the most urgent ready slot and ages the others.
// ----------------------------------------------------------------------------
// Create, make ready, remove, set priority and read priority complete in the
// cycle they are accepted, and the next transaction can follow right after
// them unless their result has to wait for the output register. Schedule
// rotates the ring of TASK_SLOTS cells past the head unit: one rotation to
// scan, a second one only when a user task (index above 1) wins, to age the
// others. While a schedule runs, no transaction is accepted. One finished
// result may wait in the output register while the next transaction is
// taken. Configuration writes are accepted in every cycle and take effect
// from the next cycle on, an aging pass in progress included, so they belong
// between transactions.
module aging_priority_scheduler
    import aps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [3:0]        aging_step,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        op,
    input  logic [3:0]        task_index,
    input  logic signed [7:0] priority_value,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [3:0]        selected_task,
    output logic              none_ready,
    output logic signed [5:0] priority_read
);

    top_state_t        state_reg, state_next;
    logic [3:0]        aging_step_reg;
    logic              out_valid_reg;
    logic [3:0]        sel_task_reg;
    logic              none_reg;
    logic signed [5:0] prio_rd_reg;
    logic [3:0]        hold_task_reg, hold_task_next;
    logic              hold_none_reg, hold_none_next;
    logic signed [5:0] hold_prio_reg, hold_prio_next;

    logic              accept;
    logic              out_free;
    logic              slot_ok;
    logic              out_load;
    logic [3:0]        load_task;
    logic              load_none;
    logic signed [5:0] load_prio;
    logic signed [5:0] rd_base;
    logic signed [5:0] clamped;
    logic              seq_start;
    logic              seq_shift;
    cell_ctl_t         ctl;
    sched_res_t        res;
    slot_t             feedback;
    slot_t             slots [TASK_SLOTS];
    logic              sel [TASK_SLOTS];

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign slot_ok  = int'(task_index) < TASK_SLOTS;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aging_step_reg <= 4'd1;
        end
        else if (cfg_valid)
        begin
            aging_step_reg <= aging_step;
        end
    end

    // priority clamp for set priority
    always_comb
    begin
        if (priority_value < PRIO_HIGHEST)
        begin
            clamped = PRIO_HIGHEST[5:0];
        end
        else if (priority_value > PRIO_LOWEST)
        begin
            clamped = PRIO_LOWEST[5:0];
        end
        else
        begin
            clamped = priority_value[5:0];
        end
    end

    // base priority of the addressed slot
    always_comb
    begin
        rd_base = 6'sd0;
        for (int i = 0; i < TASK_SLOTS; i++)
        begin
            if (int'(task_index) == i)
            begin
                rd_base = slots[i].base;
            end
        end
    end

    // cell control group
    always_comb
    begin
        ctl.shift     = seq_shift;
        ctl.wr_create = 1'b0;
        ctl.wr_ready  = 1'b0;
        ctl.wr_remove = 1'b0;
        ctl.wr_prio   = 1'b0;
        ctl.prio      = clamped;
        if (accept && slot_ok)
        begin
            unique case (op)
                OP_CREATE:   ctl.wr_create = 1'b1;
                OP_READY:    ctl.wr_ready  = 1'b1;
                OP_REMOVE:   ctl.wr_remove = 1'b1;
                OP_SET_PRIO: ctl.wr_prio   = 1'b1;
                default:     ctl.wr_prio   = 1'b0;
            endcase
        end
    end

    // ring of slot cells, head at cell zero
    for (genvar i = 0; i < TASK_SLOTS; i++)
    begin : g_cell
        assign sel[i] = (int'(task_index) == i);
        if (i == TASK_SLOTS - 1)
        begin : g_tail
            aps_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl),
                .sel      (sel[i]),
                .shift_in (feedback),
                .slot     (slots[i])
            );
        end
        else
        begin : g_body
            aps_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl),
                .sel      (sel[i]),
                .shift_in (slots[i+1]),
                .slot     (slots[i])
            );
        end
    end

    // schedule sequencer
    aps_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (seq_start),
        .aging_step (aging_step_reg),
        .head       (slots[0]),
        .feedback   (feedback),
        .shift      (seq_shift),
        .res        (res)
    );

    // transaction control and result routing
    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        seq_start      = 1'b0;
        out_load       = 1'b0;
        load_task      = 4'd0;
        load_none      = 1'b0;
        load_prio      = 6'sd0;
        hold_task_next = hold_task_reg;
        hold_none_next = hold_none_reg;
        hold_prio_next = hold_prio_reg;
        unique case (state_reg)
            TP_IDLE:
            begin
                in_ready = 1'b1;
                if ((op == OP_READ) && slot_ok)
                begin
                    load_prio = rd_base;
                end
                if (accept)
                begin
                    if (op == OP_SCHEDULE)
                    begin
                        seq_start  = 1'b1;
                        state_next = TP_BUSY;
                    end
                    else if (out_free)
                    begin
                        out_load = 1'b1;
                    end
                    else
                    begin
                        hold_task_next = load_task;
                        hold_none_next = load_none;
                        hold_prio_next = load_prio;
                        state_next     = TP_HOLD;
                    end
                end
            end
            TP_BUSY:
            begin
                load_task = res.none ? 4'd0 : 4'(res.best);
                load_none = res.none;
                if (res.done)
                begin
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        state_next = TP_IDLE;
                    end
                    else
                    begin
                        hold_task_next = load_task;
                        hold_none_next = load_none;
                        hold_prio_next = load_prio;
                        state_next     = TP_HOLD;
                    end
                end
            end
            TP_HOLD:
            begin
                load_task = hold_task_reg;
                load_none = hold_none_reg;
                load_prio = hold_prio_reg;
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = TP_IDLE;
                end
            end
            default:
            begin
                state_next = TP_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= TP_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        hold_task_reg <= hold_task_next;
        hold_none_reg <= hold_none_next;
        hold_prio_reg <= hold_prio_next;
        if (out_load)
        begin
            sel_task_reg <= load_task;
            none_reg     <= load_none;
            prio_rd_reg  <= load_prio;
        end
    end

    assign out_valid     = out_valid_reg;
    assign selected_task = sel_task_reg;
    assign none_ready    = none_reg;
    assign priority_read = prio_rd_reg;

endmodule

FILE: sv/aps_checker.sv
// ----------------------------------------------------------------------------
// aps_checker
// Port level checks for the aging priority scheduler, bound to the top
// level.
// ----------------------------------------------------------------------------
module aps_checker
    import aps_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [3:0]        selected_task,
    input logic              none_ready,
    input logic signed [5:0] priority_read
);

    // empty schedule reports slot zero
    a_none_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && none_ready) |-> (selected_task == 4'd0))
        else $error("none_ready with nonzero selected_task");

    // an empty schedule result carries no priority
    a_none_prio: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && none_ready) |-> (priority_read == 6'sd0))
        else $error("none_ready with nonzero priority_read");

    // read priority stays in the clamped range
    a_prio_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((priority_read >= -6'sd20) && (priority_read <= 6'sd20)))
        else $error("priority_read out of range");

    // stalled result stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped while stalled");

    // an accepted transaction leaves a result or holds off the input
    a_in_follow: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (out_valid || !in_ready))
        else $error("accepted transaction left no trace");

endmodule

bind aging_priority_scheduler aps_checker u_aps_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .selected_task (selected_task),
    .none_ready    (none_ready),
    .priority_read (priority_read)
);
